[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checkers of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define OIL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/oil_pkg.sv]
// ----------------------------------------------------------------------------
// oil_pkg
// Types, sizes and codes shared by the ordered identifier list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package oil_pkg;

    // List size and identifier width
    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = (ID_BITS < 16) ? ID_BITS : 16;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CNT_W:0]    wide_t;
    typedef logic [ID_W-1:0]   id_t;

    // Operation and status codes
    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_PREPEND = 2'd1,
        CMD_REMOVE  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Channel payloads
    typedef struct packed {
        cmd_t        command;
        logic [15:0] item_id;
    } op_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] entry_count;
    } res_t;

    // Datapath selects and counter operations
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_P_DN1,
        RD_P_DN2,
        RD_P_UP1,
        RD_P_UP2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_P,
        WA_LEN,
        WA_ZERO
    } wr_addr_sel_t;

    typedef enum logic {
        WD_ID,
        WD_RDATA
    } wr_data_sel_t;

    typedef enum logic [2:0] {
        P_HOLD,
        P_LEN,
        P_ZERO,
        P_INC,
        P_DEC
    } p_op_t;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_INC,
        LEN_DEC
    } len_op_t;

    // Controller to datapath
    typedef struct packed {
        logic         load;
        logic         rd_en;
        rd_sel_t      rd_sel;
        logic         wr_en;
        wr_addr_sel_t wr_addr_sel;
        wr_data_sel_t wr_data_sel;
        p_op_t        p_op;
        len_op_t      len_op;
        logic         res_load;
        status_t      res_status;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t command;
        logic full;
        logic empty;
        logic hit;
        logic p_is_one;
        logic p_up1_is_len;
        logic p_up2_is_len;
    } dp_stat_t;

endpackage

`default_nettype wire

[sv/oil_datapath.sv]
// ----------------------------------------------------------------------------
// oil_datapath
// Entry memory, scan pointer, entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oil_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire oil_pkg::op_t      op,
    input  wire oil_pkg::dp_cmd_t  dp_cmd,
    output oil_pkg::dp_stat_t      dp_stat,
    output oil_pkg::res_t          res
);

    oil_pkg::id_t   mem [oil_pkg::DEPTH];
    oil_pkg::id_t   rdata_reg;
    oil_pkg::id_t   id_reg;
    oil_pkg::cmd_t  command_reg;
    oil_pkg::addr_t p_reg;
    oil_pkg::addr_t p_next;
    oil_pkg::cnt_t  len_reg;
    oil_pkg::cnt_t  len_next;
    oil_pkg::res_t  res_reg;
    oil_pkg::addr_t rd_addr;
    oil_pkg::addr_t wr_addr;
    oil_pkg::id_t   wr_data;
    oil_pkg::wide_t p_up1;
    oil_pkg::wide_t p_up2;

    // Select the read address around the pointer
    always_comb
    begin
        case (dp_cmd.rd_sel)
            oil_pkg::RD_ZERO:  rd_addr = '0;
            oil_pkg::RD_P_DN1: rd_addr = p_reg - oil_pkg::addr_t'(1);
            oil_pkg::RD_P_DN2: rd_addr = p_reg - oil_pkg::addr_t'(2);
            oil_pkg::RD_P_UP1: rd_addr = p_reg + oil_pkg::addr_t'(1);
            oil_pkg::RD_P_UP2: rd_addr = p_reg + oil_pkg::addr_t'(2);
            default:           rd_addr = '0;
        endcase
    end

    // Select the write address and data
    always_comb
    begin
        case (dp_cmd.wr_addr_sel)
            oil_pkg::WA_P:    wr_addr = p_reg;
            oil_pkg::WA_LEN:  wr_addr = len_reg[oil_pkg::ADDR_W-1:0];
            oil_pkg::WA_ZERO: wr_addr = '0;
            default:          wr_addr = '0;
        endcase
        wr_data = (dp_cmd.wr_data_sel == oil_pkg::WD_ID) ? id_reg : rdata_reg;
    end

    // Entry memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (dp_cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Advance the pointer and the entry count
    always_comb
    begin
        case (dp_cmd.p_op)
            oil_pkg::P_HOLD: p_next = p_reg;
            oil_pkg::P_LEN:  p_next = len_reg[oil_pkg::ADDR_W-1:0];
            oil_pkg::P_ZERO: p_next = '0;
            oil_pkg::P_INC:  p_next = p_reg + oil_pkg::addr_t'(1);
            oil_pkg::P_DEC:  p_next = p_reg - oil_pkg::addr_t'(1);
            default:         p_next = p_reg;
        endcase
        case (dp_cmd.len_op)
            oil_pkg::LEN_HOLD: len_next = len_reg;
            oil_pkg::LEN_INC:  len_next = len_reg + oil_pkg::cnt_t'(1);
            oil_pkg::LEN_DEC:  len_next = len_reg - oil_pkg::cnt_t'(1);
            default:           len_next = len_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    // Hold the operation, pointer and result payload
    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        if (dp_cmd.load)
        begin
            id_reg      <= oil_pkg::id_t'(op.item_id);
            command_reg <= op.command;
        end
        if (dp_cmd.res_load)
        begin
            res_reg.status      <= dp_cmd.res_status;
            res_reg.entry_count <= 5'(len_reg);
        end
    end

    // Report flags to the controller
    always_comb
    begin
        p_up1 = oil_pkg::wide_t'(p_reg) + oil_pkg::wide_t'(1);
        p_up2 = oil_pkg::wide_t'(p_reg) + oil_pkg::wide_t'(2);
        dp_stat.command      = command_reg;
        dp_stat.full         = (len_reg == oil_pkg::cnt_t'(oil_pkg::DEPTH));
        dp_stat.empty        = (len_reg == '0);
        dp_stat.hit          = (rdata_reg == id_reg);
        dp_stat.p_is_one     = (p_reg == oil_pkg::addr_t'(1));
        dp_stat.p_up1_is_len = (p_up1 == oil_pkg::wide_t'(len_reg));
        dp_stat.p_up2_is_len = (p_up2 == oil_pkg::wide_t'(len_reg));
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[sv/oil_ctrl.sv]
// ----------------------------------------------------------------------------
// oil_ctrl
// Sequencer for append, prepend and keyed remove, and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module oil_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              op_valid,
    output logic                   op_stall,
    output logic                   res_valid,
    input  wire logic              res_stall,
    input  wire oil_pkg::dp_stat_t dp_stat,
    output oil_pkg::dp_cmd_t       dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PRE_SHIFT,
        S_PRE_HEAD,
        S_SCAN,
        S_RM_READ,
        S_RM_SHIFT,
        S_FINISH
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    oil_pkg::status_t  status_reg;
    oil_pkg::status_t  status_next;
    logic              res_valid_reg;
    logic              res_valid_next;

    // Sequence the datapath
    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;
        dp_cmd         = '0;

        // Drop the result once transferred
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    dp_cmd.load = 1'b1;
                    dp_cmd.p_op = oil_pkg::P_LEN;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                status_next = oil_pkg::ST_DONE;
                state_next  = S_FINISH;
                case (dp_stat.command)
                    oil_pkg::CMD_APPEND:
                    begin
                        if (dp_stat.full)
                        begin
                            status_next = oil_pkg::ST_FULL;
                        end
                        else
                        begin
                            dp_cmd.wr_en       = 1'b1;
                            dp_cmd.wr_addr_sel = oil_pkg::WA_LEN;
                            dp_cmd.wr_data_sel = oil_pkg::WD_ID;
                            dp_cmd.len_op      = oil_pkg::LEN_INC;
                        end
                    end
                    oil_pkg::CMD_PREPEND:
                    begin
                        if (dp_stat.full)
                        begin
                            status_next = oil_pkg::ST_FULL;
                        end
                        else if (dp_stat.empty)
                        begin
                            dp_cmd.wr_en       = 1'b1;
                            dp_cmd.wr_addr_sel = oil_pkg::WA_ZERO;
                            dp_cmd.wr_data_sel = oil_pkg::WD_ID;
                            dp_cmd.len_op      = oil_pkg::LEN_INC;
                        end
                        else
                        begin
                            // Fetch the tail entry to open the shift
                            dp_cmd.rd_en  = 1'b1;
                            dp_cmd.rd_sel = oil_pkg::RD_P_DN1;
                            state_next    = S_PRE_SHIFT;
                        end
                    end
                    oil_pkg::CMD_REMOVE:
                    begin
                        if (dp_stat.empty)
                        begin
                            status_next = oil_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            dp_cmd.rd_en  = 1'b1;
                            dp_cmd.rd_sel = oil_pkg::RD_ZERO;
                            dp_cmd.p_op   = oil_pkg::P_ZERO;
                            state_next    = S_SCAN;
                        end
                    end
                    default:
                    begin
                        status_next = oil_pkg::ST_DONE;
                    end
                endcase
            end
            S_PRE_SHIFT:
            begin
                // Move one entry up towards the tail, fetch the next one down
                dp_cmd.wr_en       = 1'b1;
                dp_cmd.wr_addr_sel = oil_pkg::WA_P;
                dp_cmd.wr_data_sel = oil_pkg::WD_RDATA;
                if (dp_stat.p_is_one)
                begin
                    state_next = S_PRE_HEAD;
                end
                else
                begin
                    dp_cmd.rd_en  = 1'b1;
                    dp_cmd.rd_sel = oil_pkg::RD_P_DN2;
                    dp_cmd.p_op   = oil_pkg::P_DEC;
                end
            end
            S_PRE_HEAD:
            begin
                dp_cmd.wr_en       = 1'b1;
                dp_cmd.wr_addr_sel = oil_pkg::WA_ZERO;
                dp_cmd.wr_data_sel = oil_pkg::WD_ID;
                dp_cmd.len_op      = oil_pkg::LEN_INC;
                status_next        = oil_pkg::ST_DONE;
                state_next         = S_FINISH;
            end
            S_SCAN:
            begin
                // Compare the fetched entry while fetching the next one
                if (dp_stat.hit)
                begin
                    state_next = S_RM_READ;
                end
                else if (dp_stat.p_up1_is_len)
                begin
                    status_next = oil_pkg::ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
                else
                begin
                    dp_cmd.rd_en  = 1'b1;
                    dp_cmd.rd_sel = oil_pkg::RD_P_UP1;
                    dp_cmd.p_op   = oil_pkg::P_INC;
                end
            end
            S_RM_READ:
            begin
                status_next = oil_pkg::ST_DONE;
                if (dp_stat.p_up1_is_len)
                begin
                    dp_cmd.len_op = oil_pkg::LEN_DEC;
                    state_next    = S_FINISH;
                end
                else
                begin
                    dp_cmd.rd_en  = 1'b1;
                    dp_cmd.rd_sel = oil_pkg::RD_P_UP1;
                    state_next    = S_RM_SHIFT;
                end
            end
            S_RM_SHIFT:
            begin
                // Close the gap one entry at a time
                dp_cmd.wr_en       = 1'b1;
                dp_cmd.wr_addr_sel = oil_pkg::WA_P;
                dp_cmd.wr_data_sel = oil_pkg::WD_RDATA;
                if (dp_stat.p_up2_is_len)
                begin
                    dp_cmd.len_op = oil_pkg::LEN_DEC;
                    state_next    = S_FINISH;
                end
                else
                begin
                    dp_cmd.rd_en  = 1'b1;
                    dp_cmd.rd_sel = oil_pkg::RD_P_UP2;
                    dp_cmd.p_op   = oil_pkg::P_INC;
                end
            end
            S_FINISH:
            begin
                // Load the result once the output register is free
                if (!res_valid_reg || !res_stall)
                begin
                    dp_cmd.res_load   = 1'b1;
                    dp_cmd.res_status = status_reg;
                    res_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= oil_pkg::ST_DONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign op_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

[sv/ordered_id_list_with_keyed_remove.sv]
// ----------------------------------------------------------------------------
// ordered_id_list_with_keyed_remove
// Ordered list of identifiers with append, prepend and remove by key.
// ----------------------------------------------------------------------------
// Usage:
//   The op channel (op_valid, op_stall, op) carries a command and an
//   identifier; a transfer takes place when op_valid is high and op_stall low.
//   Each transfer gives exactly one transfer on the res channel (res_valid,
//   res_stall, res) with a status and the entry count after the operation.
//   Operations run one at a time; op_stall is high from the cycle after a
//   transfer until the result is loaded into the output register.
//   Steps from op transfer to the result being loaded:
//     append, refused insert, unknown command, remove on empty: dispatch only
//     prepend: one memory move a cycle from the tail, then the head write
//     remove: scan from the head; on a match, shift the later entries down
//   The entry memory has one read and one write port; the next op can be
//   taken in the cycle after the result is loaded.
//   A new operation is taken while the previous result still waits; if the
//   receiver stalls, the finished operation waits until the output is free.
//   Reset empties the list at once; entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_id_list_with_keyed_remove (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         op_valid,
    output logic              op_stall,
    input  wire oil_pkg::op_t op,
    output logic              res_valid,
    input  wire logic         res_stall,
    output oil_pkg::res_t     res
);

    oil_pkg::dp_cmd_t  dp_cmd;
    oil_pkg::dp_stat_t dp_stat;

    // Sequencer
    oil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    // Entry store and counters
    oil_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat),
        .res     (res)
    );

endmodule

`default_nettype wire

[sv/oil_checker.sv]
// ----------------------------------------------------------------------------
// oil_checker
// Port-level checks for the ordered identifier list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module oil_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         op_valid,
    input wire logic         op_stall,
    input wire oil_pkg::op_t op,
    input wire logic         res_valid,
    input wire logic         res_stall,
    input wire oil_pkg::res_t res
);

    localparam logic [4:0] FULL_COUNT = 5'(oil_pkg::DEPTH);

    logic op_xfer;
    logic op_wait;
    logic res_wait;
    logic res_full;

    assign op_xfer  = op_valid && !op_stall;
    assign op_wait  = op_valid && op_stall;
    assign res_wait = res_valid && res_stall;
    assign res_full = res_valid && (res.status == oil_pkg::ST_FULL);

    // A stalled operation holds
    `OIL_ASSERT_NEXT(a_op_hold, clk, rst_n, op_wait, op_valid && $stable(op), "op changed")

    // A stalled result holds
    `OIL_ASSERT_NEXT(a_res_hold, clk, rst_n, res_wait, res_valid && $stable(res), "res changed")

    // One operation at a time: the op channel closes after a transfer
    `OIL_ASSERT_NEXT(a_one_op, clk, rst_n, op_xfer, op_stall, "op accepted while busy")

    // A refused insert reports a full list
    `OIL_ASSERT_SAME(a_full_count, clk, rst_n, res_full, res.entry_count == FULL_COUNT, "bad count")

endmodule

bind ordered_id_list_with_keyed_remove oil_checker u_checker (.*);

`default_nettype wire
